@@ src/raabb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ray versus box slab test.
// No dependencies.
package raabb_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + COORD_W;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // Pipeline depth: three lane stages, two merge stages.
  localparam int LANE_LAT = 3;
  localparam int MERGE_LAT = 2;
  localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // Near and far slab distances found by one axis lane.
  typedef struct packed {
    coord_t near_d;
    coord_t far_d;
  } slab_pair_t;

endpackage

@@ src/ray_aabb_slab_test.sv @@
`timescale 1ns / 1ps
// Top level of the ray versus axis-aligned box slab test.
// Depends on raabb_pkg, raabb_lane and raabb_merge.
//
// Tests one ray per clock against the box held in six configuration
// registers. A request is taken at each rising edge with start high and busy
// low; busy is low except during reset, so a new ray can enter every cycle.
// Each request gives exactly one result: done pulses for one cycle with hit
// and distance (entry on a hit, exit on a miss, signed fixed point with
// FRAC_BITS fraction bits). The result passes through the lane pipeline
// (difference, multiply, shift and saturate) and two merge stages.
// The receiver has no way to stall; results must be taken as they appear.
// Write the box registers only when no request is in flight.
module ray_aabb_slab_test import raabb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   origin_x,
  input  logic signed [31:0]   origin_y,
  input  logic signed [31:0]   origin_z,
  input  logic signed [31:0]   inv_dir_x,
  input  logic signed [31:0]   inv_dir_y,
  input  logic signed [31:0]   inv_dir_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata,
  output logic                 done,
  output logic                 hit,
  output logic signed [31:0]   distance
);

  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  logic [PIPE_LAT-1:0] vld;
  slab_pair_t          slab_x;
  slab_pair_t          slab_y;
  slab_pair_t          slab_z;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      box_max_z <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BOX_MIN_X: box_min_x <= cfg_wdata;
        REG_BOX_MIN_Y: box_min_y <= cfg_wdata;
        REG_BOX_MIN_Z: box_min_z <= cfg_wdata;
        REG_BOX_MAX_X: box_max_x <= cfg_wdata;
        REG_BOX_MAX_Y: box_max_y <= cfg_wdata;
        REG_BOX_MAX_Z: box_max_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Track each request down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_LAT-1];

  raabb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk       (clk),
    .origin    (origin_x),
    .inv_dir   (inv_dir_x),
    .corner_lo (box_min_x),
    .corner_hi (box_max_x),
    .slab      (slab_x)
  );

  raabb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk       (clk),
    .origin    (origin_y),
    .inv_dir   (inv_dir_y),
    .corner_lo (box_min_y),
    .corner_hi (box_max_y),
    .slab      (slab_y)
  );

  raabb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk       (clk),
    .origin    (origin_z),
    .inv_dir   (inv_dir_z),
    .corner_lo (box_min_z),
    .corner_hi (box_max_z),
    .slab      (slab_z)
  );

  raabb_merge u_merge (
    .clk      (clk),
    .slab_x   (slab_x),
    .slab_y   (slab_y),
    .slab_z   (slab_z),
    .hit      (hit),
    .distance (distance)
  );

endmodule

@@ src/raabb_lane.sv @@
`timescale 1ns / 1ps
// One axis lane: both slab distances of an axis, floor-shifted and saturated.
// Depends on raabb_pkg.
module raabb_lane import raabb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  coord_t     origin,
  input  coord_t     inv_dir,
  input  coord_t     corner_lo,
  input  coord_t     corner_hi,
  output slab_pair_t slab
);

  logic signed [DIFF_W-1:0] diff_lo;
  logic signed [DIFF_W-1:0] diff_hi;
  coord_t                   inv_q;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi;
  coord_t                   dist_lo;
  coord_t                   dist_hi;

  function automatic coord_t scale_sat(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] shifted;
    logic [PROD_W-COORD_W:0]  top_bits;
    shifted  = prod >>> FRAC_BITS;
    top_bits = shifted[PROD_W-1:COORD_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      return shifted[COORD_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  // Stage 1: exact 33-bit differences.
  always_ff @(posedge clk) begin
    diff_lo <= {corner_lo[COORD_W-1], corner_lo} - {origin[COORD_W-1], origin};
    diff_hi <= {corner_hi[COORD_W-1], corner_hi} - {origin[COORD_W-1], origin};
    inv_q   <= inv_dir;
  end

  // Stage 2: full products.
  always_ff @(posedge clk) begin
    prod_lo <= diff_lo * inv_q;
    prod_hi <= diff_hi * inv_q;
  end

  // Stage 3: shift with floor rounding, saturate, order the pair.
  always_comb begin
    dist_lo = scale_sat(prod_lo);
    dist_hi = scale_sat(prod_hi);
  end

  always_ff @(posedge clk) begin
    if (dist_lo < dist_hi) begin
      slab.near_d <= dist_lo;
      slab.far_d  <= dist_hi;
    end else begin
      slab.near_d <= dist_hi;
      slab.far_d  <= dist_lo;
    end
  end

endmodule

@@ src/raabb_merge.sv @@
`timescale 1ns / 1ps
// Merge of the three axis lanes into entry and exit, then the hit decision.
// Depends on raabb_pkg.
module raabb_merge import raabb_pkg::*; (
  input  logic       clk,
  input  slab_pair_t slab_x,
  input  slab_pair_t slab_y,
  input  slab_pair_t slab_z,
  output logic       hit,
  output coord_t     distance
);

  coord_t near_xy;
  coord_t far_xy;
  coord_t entry_d;
  coord_t exit_d;
  logic   is_hit;

  always_comb begin
    near_xy = (slab_x.near_d > slab_y.near_d) ? slab_x.near_d : slab_y.near_d;
    far_xy  = (slab_x.far_d < slab_y.far_d) ? slab_x.far_d : slab_y.far_d;
  end

  // Stage 4: entry is the latest near, exit the earliest far.
  always_ff @(posedge clk) begin
    entry_d <= (near_xy > slab_z.near_d) ? near_xy : slab_z.near_d;
    exit_d  <= (far_xy < slab_z.far_d) ? far_xy : slab_z.far_d;
  end

  // Miss when the box is behind the origin or the slabs do not overlap.
  assign is_hit = !(exit_d[COORD_W-1] || (entry_d > exit_d));

  // Stage 5: result register.
  always_ff @(posedge clk) begin
    hit      <= is_hit;
    distance <= is_hit ? entry_d : exit_d;
  end

endmodule

@@ src/raabb_check.sv @@
`timescale 1ns / 1ps
// Port-level checks for ray_aabb_slab_test and the bind that attaches them.
// Depends on raabb_pkg.
module raabb_check import raabb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [31:0] distance
);

  // Every request yields a result at the end of the pipeline.
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("request without result");

  // No result appears without a request.
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without request");

  // The pipeline is empty right after reset.
  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result right after reset");

  // Outside reset the block never holds requests off.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy outside reset");

  // A result never carries unknown bits.
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({hit, distance}))
    else $error("unknown result");

endmodule

bind ray_aabb_slab_test raabb_check u_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit      (hit),
  .distance (distance)
);
